@@ rtl/core/size_class_block_allocator_assert.svh @@
// Assertion macros for the size class block allocator checker.
`ifndef SIZE_CLASS_BLOCK_ALLOCATOR_ASSERT_SVH
`define SIZE_CLASS_BLOCK_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SCBA_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define SCBA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/scba_pkg.sv @@
package scba_pkg;

    localparam int unsigned POOL_CHUNKS_DEF = 64;
    localparam int unsigned CHUNK_BYTES_DEF = 16 * 1024;
    localparam int unsigned CLASS_COUNT_DEF = 14;

    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_FREE  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_ZERO  = 2'd1;
    localparam logic [1:0] ST_OVER  = 2'd2;
    localparam logic [1:0] ST_EXH   = 2'd3;

    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] req_size;
        logic [19:0] free_addr;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [19:0] block_addr;
        logic [3:0]  size_class;
        logic [16:0] live_blocks;
        logic [6:0]  chunks_used;
    } rsp_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_CARVE,
        S_POP,
        S_RESP
    } state_t;

    typedef struct packed {
        logic       load;
        logic       clear;
        logic       push;
        logic       pop_read;
        logic       pop_done;
        logic       carve_step;
        logic       carve_end;
        logic       set_status;
        logic [1:0] status;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       zero;
        logic       over;
        logic       head_vld;
        logic       pool_full;
        logic       carve_last;
        logic       out_free;
    } sts_t;

    // Block size of each class in 16-byte granules.
    function automatic logic [5:0] class_granules(logic [3:0] c);
        logic [5:0] g;
        case (c)
            4'd0:    g = 6'd1;
            4'd1:    g = 6'd2;
            4'd2:    g = 6'd4;
            4'd3:    g = 6'd6;
            4'd4:    g = 6'd8;
            4'd5:    g = 6'd10;
            4'd6:    g = 6'd12;
            4'd7:    g = 6'd14;
            4'd8:    g = 6'd16;
            4'd9:    g = 6'd20;
            4'd10:   g = 6'd24;
            4'd11:   g = 6'd28;
            4'd12:   g = 6'd32;
            4'd13:   g = 6'd40;
            default: g = 6'd40;
        endcase
        return g;
    endfunction

endpackage

@@ rtl/core/size_class_block_allocator.sv @@
// Size class block allocator. Each request word (allocate, free, clear) gives
// exactly one result word. Sizes map to up to 14 classes from 16 to 640 bytes;
// each class keeps a LIFO free list threaded through a link RAM with one entry
// per 16-byte granule of the pool. A request is accepted only while the block
// is idle. From accept to the result word in the output register: clear, free,
// zero and oversize requests pass through EXEC and RESP, an allocation served
// from its list also passes POP (the link RAM's registered read), and an
// allocation that finds its list empty and the pool not full first carves a
// fresh chunk, writing one link per cycle, one per block (up to CHUNK_BYTES/16).
// The next word is taken the cycle after the result is loaded, even if that
// result is still stalled at the output.
module size_class_block_allocator #(
    parameter int unsigned POOL_CHUNKS = scba_pkg::POOL_CHUNKS_DEF,
    parameter int unsigned CHUNK_BYTES = scba_pkg::CHUNK_BYTES_DEF,
    parameter int unsigned CLASS_COUNT = scba_pkg::CLASS_COUNT_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  scba_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output scba_pkg::rsp_t rsp
);
    import scba_pkg::*;

    cmd_t cmd;
    sts_t sts;

    scba_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    scba_dp #(
        .POOL_CHUNKS(POOL_CHUNKS),
        .CHUNK_BYTES(CHUNK_BYTES),
        .CLASS_COUNT(CLASS_COUNT)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .cmd      (cmd),
        .rsp_stall(rsp_stall),
        .sts      (sts),
        .rsp_valid(rsp_valid),
        .rsp      (rsp)
    );
endmodule

@@ rtl/core/scba_ram.sv @@
module scba_ram #(
    parameter int unsigned WIDTH = 17,
    parameter int unsigned DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end
endmodule

@@ rtl/core/scba_ctrl.sv @@
module scba_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  scba_pkg::sts_t sts,
    output scba_pkg::cmd_t cmd
);
    import scba_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   is_alloc_free;
    logic   sized;

    assign is_alloc_free = (sts.op == OP_ALLOC) || (sts.op == OP_FREE);
    assign sized         = is_alloc_free && !sts.zero && !sts.over;
    assign req_stall     = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (sized && sts.op == OP_ALLOC && sts.head_vld)
                begin
                    state_next = S_POP;
                end
                else if (sized && sts.op == OP_ALLOC && !sts.pool_full)
                begin
                    state_next = S_CARVE;
                end
                else
                begin
                    state_next = S_RESP;
                end
            end
            S_CARVE:
            begin
                if (sts.carve_last)
                begin
                    state_next = S_EXEC;
                end
            end
            S_POP:
            begin
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.load = req_valid;
            end
            S_EXEC:
            begin
                if (sts.op == OP_CLEAR)
                begin
                    cmd.clear = 1'b1;
                end
                else if (is_alloc_free && sts.zero)
                begin
                    cmd.set_status = 1'b1;
                    cmd.status     = ST_ZERO;
                end
                else if (is_alloc_free && sts.over)
                begin
                    cmd.set_status = 1'b1;
                    cmd.status     = ST_OVER;
                end
                else if (sts.op == OP_FREE)
                begin
                    cmd.push = 1'b1;
                end
                else if (sts.op == OP_ALLOC && sts.head_vld)
                begin
                    cmd.pop_read = 1'b1;
                end
                else if (sts.op == OP_ALLOC && sts.pool_full)
                begin
                    cmd.set_status = 1'b1;
                    cmd.status     = ST_EXH;
                end
            end
            S_CARVE:
            begin
                cmd.carve_step = 1'b1;
                cmd.carve_end  = sts.carve_last;
            end
            S_POP:
            begin
                cmd.pop_done = 1'b1;
            end
            S_RESP:
            begin
                cmd.out_load = sts.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end
endmodule

@@ rtl/core/scba_dp.sv @@
module scba_dp #(
    parameter int unsigned POOL_CHUNKS = scba_pkg::POOL_CHUNKS_DEF,
    parameter int unsigned CHUNK_BYTES = scba_pkg::CHUNK_BYTES_DEF,
    parameter int unsigned CLASS_COUNT = scba_pkg::CLASS_COUNT_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  scba_pkg::req_t req,
    input  scba_pkg::cmd_t cmd,
    input  logic           rsp_stall,
    output scba_pkg::sts_t sts,
    output logic           rsp_valid,
    output scba_pkg::rsp_t rsp
);
    import scba_pkg::*;

    localparam int unsigned POOL_BYTES  = POOL_CHUNKS * CHUNK_BYTES;
    localparam int unsigned STORE_DEPTH = POOL_BYTES / 16;
    localparam int unsigned GW          = $clog2(STORE_DEPTH);
    localparam int unsigned LW          = GW + 1;
    localparam int unsigned CHUNK_G     = CHUNK_BYTES / 16;
    localparam int unsigned OW          = $clog2(CHUNK_G + 1);
    localparam int unsigned BW          = $clog2(POOL_BYTES + 1);
    localparam int unsigned CW          = $clog2(POOL_CHUNKS + 1);
    localparam int unsigned CLW         = (CLASS_COUNT > 1) ? $clog2(CLASS_COUNT) : 1;
    localparam int unsigned MAX_BYTES   =
        16 * int'(class_granules(4'(CLASS_COUNT - 1)));

    logic [1:0]     op_reg;
    logic           zero_reg;
    logic           over_reg;
    logic [3:0]     cls_reg;
    logic [15:0]    free_g_reg;
    logic [1:0]     res_status_reg;
    logic [19:0]    res_addr_reg;
    logic [OW-1:0]  off_reg;
    logic [BW-1:0]  base_reg;
    logic [CW-1:0]  chunk_reg;
    logic [16:0]    live_reg;
    logic           head_vld_reg [CLASS_COUNT];
    logic [GW-1:0]  head_idx_reg [CLASS_COUNT];
    logic           rsp_valid_reg;
    rsp_t           rsp_reg;

    logic [3:0]     cls_calc;
    logic           zero_calc;
    logic           over_calc;
    logic           af_calc;
    logic [CLW-1:0] ci;
    logic [5:0]     bsg;
    logic           hv;
    logic [GW-1:0]  hi;
    logic           free_ok;
    logic [GW-1:0]  free_idx;
    logic [GW-1:0]  base_g;
    logic [GW-1:0]  carve_g;
    logic [GW-1:0]  next_g;
    logic [OW:0]    off_end;
    logic           carve_last;
    logic           ram_we;
    logic [GW-1:0]  ram_waddr;
    logic [LW-1:0]  ram_wdata;
    logic [LW-1:0]  ram_rdata;
    logic [GW+3:0]  pop_bytes;

    // Smallest class that holds the size.
    always_comb
    begin
        cls_calc = 4'(CLASS_COUNT - 1);
        for (int i = int'(CLASS_COUNT) - 2; i >= 0; i--)
        begin
            if (req.req_size <= 16'({class_granules(4'(i)), 4'b0000}))
            begin
                cls_calc = 4'(i);
            end
        end
    end

    assign zero_calc = (req.req_size == 16'd0);
    assign over_calc = (32'(req.req_size) > MAX_BYTES);
    assign af_calc   = (req.op == OP_ALLOC) || (req.op == OP_FREE);

    assign ci       = cls_reg[CLW-1:0];
    assign bsg      = class_granules(cls_reg);
    assign hv       = head_vld_reg[ci];
    assign hi       = head_idx_reg[ci];
    assign free_ok  = (32'(free_g_reg) < STORE_DEPTH);
    assign free_idx = GW'(free_g_reg);
    assign base_g   = GW'(base_reg >> 4);
    assign carve_g  = base_g + GW'(off_reg);
    assign next_g   = carve_g + GW'(bsg);
    // Last block when one more block would not fit past the next one.
    assign off_end    = (OW + 1)'(off_reg) + (OW + 1)'({bsg, 1'b0});
    assign carve_last = (off_end > (OW + 1)'(CHUNK_G));

    assign ram_we    = cmd.carve_step || (cmd.push && free_ok);
    assign ram_waddr = cmd.push ? free_idx : carve_g;
    assign ram_wdata = cmd.push ? {hv, hi} : (carve_last ? '0 : {1'b1, next_g});
    // The popped block is the current head; the link read gives the new head.
    assign pop_bytes = {hi, 4'b0000};

    scba_ram #(
        .WIDTH(LW),
        .DEPTH(STORE_DEPTH)
    ) u_link_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (cmd.pop_read),
        .raddr(hi),
        .rdata(ram_rdata)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg     <= req.op;
            zero_reg   <= zero_calc;
            over_reg   <= over_calc;
            cls_reg    <= (af_calc && !zero_calc && !over_calc) ? cls_calc : 4'd0;
            free_g_reg <= req.free_addr[19:4];
        end
        if (cmd.load)
        begin
            res_status_reg <= ST_OK;
            res_addr_reg   <= '0;
        end
        else if (cmd.set_status)
        begin
            res_status_reg <= cmd.status;
        end
        else if (cmd.pop_done)
        begin
            res_addr_reg <= 20'(pop_bytes);
        end
        if (cmd.load)
        begin
            off_reg <= '0;
        end
        else if (cmd.carve_step)
        begin
            off_reg <= off_reg + OW'(bsg);
        end
        if (cmd.push && free_ok)
        begin
            head_idx_reg[ci] <= free_idx;
        end
        else if (cmd.carve_end)
        begin
            head_idx_reg[ci] <= base_g;
        end
        else if (cmd.pop_done)
        begin
            head_idx_reg[ci] <= ram_rdata[GW-1:0];
        end
        if (cmd.out_load)
        begin
            rsp_reg.status      <= res_status_reg;
            rsp_reg.block_addr  <= res_addr_reg;
            rsp_reg.size_class  <= cls_reg;
            rsp_reg.live_blocks <= live_reg;
            rsp_reg.chunks_used <= 7'(chunk_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < int'(CLASS_COUNT); i++)
            begin
                head_vld_reg[i] <= 1'b0;
            end
            base_reg      <= '0;
            chunk_reg     <= '0;
            live_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear)
            begin
                for (int i = 0; i < int'(CLASS_COUNT); i++)
                begin
                    head_vld_reg[i] <= 1'b0;
                end
                base_reg  <= '0;
                chunk_reg <= '0;
                live_reg  <= '0;
            end
            else if (cmd.push && free_ok)
            begin
                head_vld_reg[ci] <= 1'b1;
                if (live_reg != 17'd0)
                begin
                    live_reg <= live_reg - 17'd1;
                end
            end
            else if (cmd.carve_end)
            begin
                head_vld_reg[ci] <= 1'b1;
                chunk_reg        <= chunk_reg + CW'(1);
                base_reg         <= base_reg + BW'(CHUNK_BYTES);
            end
            else if (cmd.pop_done)
            begin
                head_vld_reg[ci] <= ram_rdata[GW];
                if (live_reg != '1)
                begin
                    live_reg <= live_reg + 17'd1;
                end
            end
            if (cmd.out_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    assign sts.op         = op_reg;
    assign sts.zero       = zero_reg;
    assign sts.over       = over_reg;
    assign sts.head_vld   = hv;
    assign sts.pool_full  = (chunk_reg >= CW'(POOL_CHUNKS));
    assign sts.carve_last = carve_last;
    assign sts.out_free   = !rsp_valid_reg || !rsp_stall;

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
endmodule

@@ rtl/core/scba_checker.sv @@
`include "size_class_block_allocator_assert.svh"

module scba_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           req_valid,
    input logic           req_stall,
    input scba_pkg::req_t req,
    input logic           rsp_valid,
    input logic           rsp_stall,
    input scba_pkg::rsp_t rsp
);
    import scba_pkg::*;

    `SCBA_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall, "accepted word did not block input")
    `SCBA_ASSERT_IMPL(a_rsp_from_busy, $rose(rsp_valid), $past(req_stall), "result without a request in work")
    `SCBA_ASSERT_IMPL(a_addr_only_ok, rsp_valid && rsp.status != ST_OK, rsp.block_addr == '0, "address on a failed request")
    `SCBA_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "stalled result changed")
endmodule

bind size_class_block_allocator scba_checker u_scba_checker (.*);
